// ----- design/b2da_pkg.sv -----
// b2da_pkg: shared types, constants and sizing function for the binary to decimal ascii block
// no dependencies; used by b2da_digit_cell, binary_to_decimal_ascii_core and the bench
package b2da_pkg;

  localparam int DEFAULT_VALUE_BITS = 31;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // decimal digits of 2^bits-1, floor(bits*log10(2))+1, good up to 64 bits
  function automatic int digit_count(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // per-cycle control broadcast to every digit cell
  typedef struct packed {
    logic clear;        // zero the digit
    logic shift_bit;    // double-dabble step: adjust, then take one bit from below
    logic shift_digit;  // move whole digit up one place toward the top cell
  } cell_ctl_t;

endpackage

// ----- design/b2da_digit_cell.sv -----
// b2da_digit_cell: one bcd digit of the double-dabble chain
// depends on b2da_pkg for the control struct and digit width
module b2da_digit_cell (
  input  logic                         clk,
  input  b2da_pkg::cell_ctl_t          ctl,
  input  logic                         bit_in,
  input  logic [b2da_pkg::DIGIT_W-1:0] digit_in,
  output logic                         bit_out,
  output logic [b2da_pkg::DIGIT_W-1:0] digit
);
  import b2da_pkg::*;

  logic [DIGIT_W-1:0] adjusted;
  logic [DIGIT_W-1:0] digit_next;

  // add 3 when 5 or more so the doubling carries into the next digit
  always_comb begin
    adjusted = (digit >= DIGIT_W'(5)) ? digit + DIGIT_W'(3) : digit;
    bit_out  = adjusted[DIGIT_W-1];
  end

  always_comb begin
    digit_next = digit;
    if (ctl.clear) begin
      digit_next = '0;
    end else if (ctl.shift_bit) begin
      digit_next = {adjusted[DIGIT_W-2:0], bit_in};
    end else if (ctl.shift_digit) begin
      digit_next = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

// ----- design/binary_to_decimal_ascii_core.sv -----
// binary_to_decimal_ascii_core: top level, converts a binary word to a stream of ascii digits
// depends on b2da_pkg and b2da_digit_cell
//
// Takes one unsigned word of VALUE_BITS bits and sends its decimal digits as
// ascii codes '0'..'9', most significant first, with leading zeros dropped;
// zero gives the single character '0', and last_digit marks the final digit.
// The conversion runs on a row of bcd digit cells (double dabble): each cycle
// every cell adjusts its digit and takes one bit from its lower neighbor, the
// input word feeding the bottom cell msb first until every bit is taken in.
// The digits then move up the same row one place per cycle, though a slot that
// produces a character waits while the output register is full and out_ready
// is low; they are read at the top cell (10 digit slots at 31 bits), leading
// zero slots consumed without output. A new word is taken only once the
// previous word's last digit has reached the output register. The output
// register lets that last digit wait for out_ready while the next word is
// already converting.
module binary_to_decimal_ascii_core #(
  parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [VALUE_BITS-1:0]       value,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic [b2da_pkg::CHAR_W-1:0] digit_char,
  output logic                        last_digit,
  output logic                        out_valid,
  input  logic                        out_ready
);
  import b2da_pkg::*;

  localparam int NDIG  = digit_count(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int DIG_W = $clog2(NDIG);

  state_t state, state_next;

  logic [VALUE_BITS-1:0] shreg;       // word being fed msb first
  logic [CNT_W-1:0]      bit_cnt;
  logic [DIG_W-1:0]      dig_cnt;     // digit slots still to read, minus one
  logic                  started;     // a digit has gone out

  cell_ctl_t             ctl;
  logic [NDIG:0]         carry;
  logic [DIGIT_W-1:0]    digits [NDIG+1];

  logic [DIGIT_W-1:0]    top_digit;
  logic                  out_free;
  logic                  want_emit;   // this slot produces a character
  logic                  step;        // this slot is consumed this cycle
  logic                  accept;

  // digit row, cell 0 least significant
  assign carry[0]  = shreg[VALUE_BITS-1];
  assign digits[0] = '0;

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    b2da_digit_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .bit_in   (carry[i]),
      .digit_in (digits[i]),
      .bit_out  (carry[i+1]),
      .digit    (digits[i+1])
    );
  end

  assign top_digit = digits[NDIG];

  // emit-side decisions
  always_comb begin
    out_free  = !out_valid || out_ready;
    want_emit = started || (top_digit != '0) || (dig_cnt == '0);
    step      = (state == ST_EMIT) && (!want_emit || out_free);
    accept    = in_valid && in_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt == CNT_W'(VALUE_BITS - 1)) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (step && dig_cnt == '0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready        = 1'b0;
    ctl.clear       = 1'b0;
    ctl.shift_bit   = 1'b0;
    ctl.shift_digit = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.clear = 1'b1;
      end
      ST_CONV: begin
        ctl.shift_bit = 1'b1;
      end
      ST_EMIT: begin
        ctl.shift_digit = step;
      end
      default: begin
        ctl.clear = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input word and counters
  always_ff @(posedge clk) begin
    if (accept) begin
      shreg   <= value;
      bit_cnt <= '0;
      dig_cnt <= DIG_W'(NDIG - 1);
      started <= 1'b0;
    end else if (state == ST_CONV) begin
      shreg   <= {shreg[VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt + CNT_W'(1);
    end else if (step) begin
      dig_cnt <= dig_cnt - DIG_W'(1);
      if (want_emit) started <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && want_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && want_emit) begin
      digit_char <= ASCII_ZERO + CHAR_W'(top_digit);
      last_digit <= (dig_cnt == '0);
    end
  end

endmodule

// ----- bench/binary_to_decimal_ascii_core_tb.sv -----
// binary_to_decimal_ascii_core_tb: self-checking bench for the binary to ascii decimal converter
// depends on b2da_pkg and binary_to_decimal_ascii_core; drives words, checks the digit stream
module binary_to_decimal_ascii_core_tb;
  import b2da_pkg::*;

  localparam int VALUE_BITS = DEFAULT_VALUE_BITS;
  localparam int MAX_DIGITS = 10;
  localparam int QUIET_LIMIT = 5000;   // cycles with no word moving on either side
  localparam int BACKUP_CYCLES = 400;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } digit_exp_t;

  typedef enum logic [2:0] {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH,
    PH_BACKUP
  } phase_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     digit_char;
  logic                  last_digit;
  logic                  out_valid;
  logic                  out_ready = 1'b0;

  logic [VALUE_BITS-1:0] pending_words[$];
  digit_exp_t            expected_digits[$];
  phase_t                phase = PH_STEADY;
  int                    gap_pct = 0;
  int                    stall_pct = 0;
  int                    words_queued = 0;
  int                    words_taken = 0;
  int                    mismatches = 0;
  int                    quiet_cycles = 0;
  int                    hold_left = 0;
  logic                  hold_done = 1'b0;
  logic                  word_taken = 1'b0;

  binary_to_decimal_ascii_core #(.VALUE_BITS(VALUE_BITS)) uut (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .digit_char(digit_char),
    .last_digit(last_digit),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // decimal digits of one word, most significant first, last one flagged
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] word);
    logic [3:0]  digs[MAX_DIGITS];
    logic [31:0] rest;
    int          n;
    digit_exp_t  e;
    rest = 32'(word);
    n = 0;
    do begin
      digs[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      e.code = ASCII_ZERO + CHAR_W'(digs[k]);
      e.last = (k == 0);
      expected_digits.push_back(e);
    end
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  // sender: a new word goes out only once the one on the bus was taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || word_taken) begin
        if (pending_words.size() != 0 &&
            (gap_pct == 0 || $urandom_range(0, 99) >= gap_pct)) begin
          value <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off in the backup phase
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (phase == PH_BACKUP && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= BACKUP_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // monitor: predict on every taken word, check every taken digit
  always @(posedge clk) begin
    digit_exp_t e;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_digits(value);
        words_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          flag_error($sformatf("unexpected digit char %0d last %0b", digit_char, last_digit));
        end else begin
          e = expected_digits.pop_front();
          if (digit_char !== e.code || last_digit !== e.last) begin
            flag_error($sformatf("expected char %0d last %0b, got char %0d last %0b",
                                 e.code, e.last, digit_char, last_digit));
          end
        end
      end
    end
  end

  // watchdog: too long with nothing moving means the block is stuck
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("binary_to_decimal_ascii_core_tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // queue a batch of random words under one idling pattern, wait until all are taken
  task automatic run_phase(input phase_t ph, input int n_words, input int gaps,
                           input int stalls);
    logic [31:0] pow10;
    logic [31:0] w;
    int          width;
    int          pick;
    phase = ph;
    gap_pct = gaps;
    stall_pct = stalls;
    for (int i = 0; i < n_words; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // random magnitude so digit counts spread over 1..10
        width = $urandom_range(1, VALUE_BITS);
        w = $urandom & (32'h7FFF_FFFF >> (VALUE_BITS - width));
      end else if (pick < 85) begin
        // just around a power of ten, where the digit count changes
        pow10 = 1;
        repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
        w = pow10 + $urandom_range(0, 2) - 1;
      end else begin
        w = $urandom;
      end
      pending_words.push_back(w[VALUE_BITS-1:0]);
      words_queued++;
    end
    while (words_taken != words_queued) @(posedge clk);
  endtask

  initial begin
    static logic [31:0] directed_words[] = '{
      0, 1, 9, 10, 99, 100, 101, 999, 1000, 12345, 99999, 100000, 999999,
      1000000, 9999999, 10000000, 99999999, 100000000, 999999999, 1000000000,
      1234567890, 2147483646, 2147483647, 32'h2AAA_AAAA, 32'h5555_5555
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: zero, all ones, every digit count and most of the digit count boundaries
    foreach (directed_words[i]) begin
      pending_words.push_back(directed_words[i][VALUE_BITS-1:0]);
      words_queued++;
    end
    while (words_taken != words_queued) @(posedge clk);

    run_phase(PH_STEADY, 15, 0, 0);
    run_phase(PH_SEND_GAPS, 15, 83, 0);
    run_phase(PH_RECV_STALLS, 15, 0, 83);
    run_phase(PH_BOTH, 20, 11, 11);
    // sender keeps offering while the receiver holds off, block backs up
    run_phase(PH_BACKUP, 10, 0, 0);

    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("binary_to_decimal_ascii_core_tb: PASS");
    end else begin
      $display("binary_to_decimal_ascii_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/b2da_pkg.sv
design/b2da_digit_cell.sv
design/binary_to_decimal_ascii_core.sv
bench/binary_to_decimal_ascii_core_tb.sv
